>>> hdl/bfm_pkg.sv
// Shared constants, command codes and controller/datapath handshake types.
`timescale 1ns / 1ps
`default_nettype none
package bfm_pkg;

  localparam int unsigned PROG_DEPTH_DEF  = 4096;
  localparam int unsigned TAPE_CELLS_DEF  = 1024;
  localparam int unsigned STACK_DEPTH_DEF = 256;

  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_RESTART = 2'd1;
  localparam logic [1:0] ACT_STEP    = 2'd2;
  localparam logic [1:0] ACT_NONE    = 2'd3;

  typedef enum logic [2:0] {
    OP_RIGHT = 3'd0,
    OP_LEFT  = 3'd1,
    OP_INC   = 3'd2,
    OP_DEC   = 3'd3,
    OP_OUT   = 3'd4,
    OP_IN    = 3'd5,
    OP_OPEN  = 3'd6,
    OP_CLOSE = 3'd7
  } op_t;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_END     = 3'd1;
  localparam logic [2:0] ST_BRACKET = 3'd2;
  localparam logic [2:0] ST_TAPE    = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  typedef struct packed {
    logic ok;
    op_t  op;
  } dec_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic clr_init;
    logic clear;
    logic restart;
    logic load;
    logic close1;
    logic close2;
    logic exec;
    logic move;
    logic nop;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic close_ok;
    logic moved;
  } sts_t;

  function automatic dec_t decode(input logic [7:0] c);
    dec_t d;
    d.ok = 1'b1;
    d.op = OP_RIGHT;
    case (c)
      8'h3E: d.op = OP_RIGHT;
      8'h3C: d.op = OP_LEFT;
      8'h2B: d.op = OP_INC;
      8'h2D: d.op = OP_DEC;
      8'h2E: d.op = OP_OUT;
      8'h2C: d.op = OP_IN;
      8'h5B: d.op = OP_OPEN;
      8'h5D: d.op = OP_CLOSE;
      default: d.ok = 1'b0;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

>>> hdl/bfm_ctrl.sv
// Controller state machine sequencing load, restart, step and no-op items, and the clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none
module bfm_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  input  wire  [1:0]        action,
  input  bfm_pkg::sts_t     sts,
  output logic              busy,
  output logic              done,
  output bfm_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_CLEAR, S_LOAD, S_CLOSE1, S_CLOSE2, S_STEP, S_MOVE, S_NOP
  } state_t;

  state_t state;
  logic   from_item;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.accept   = start && (state == S_IDLE);
    cmd.clr_init = cmd.accept && (action == bfm_pkg::ACT_RESTART);
    cmd.clear    = (state == S_CLEAR);
    cmd.restart  = (state == S_CLEAR) && sts.clr_last;
    cmd.load     = (state == S_LOAD);
    cmd.close1   = (state == S_CLOSE1);
    cmd.close2   = (state == S_CLOSE2);
    cmd.exec     = (state == S_STEP);
    cmd.move     = (state == S_MOVE);
    cmd.nop      = (state == S_NOP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      from_item <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            from_item <= 1'b1;
            case (action)
              bfm_pkg::ACT_LOAD:    state <= S_LOAD;
              bfm_pkg::ACT_RESTART: state <= S_CLEAR;
              bfm_pkg::ACT_STEP:    state <= S_STEP;
              default:              state <= S_NOP;
            endcase
          end
        end
        S_CLEAR: begin
          if (sts.clr_last) begin
            state <= S_IDLE;
            done  <= from_item;
          end
        end
        S_LOAD: begin
          if (sts.close_ok) begin
            state <= S_CLOSE1;
          end else begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        S_CLOSE1: state <= S_CLOSE2;
        S_STEP: begin
          if (sts.moved) begin
            state <= S_MOVE;
          end else begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        S_CLOSE2, S_MOVE, S_NOP: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hdl/bfm_dp.sv
// Datapath: program, jump, stack and tape memories with machine registers.
`timescale 1ns / 1ps
`default_nettype none
module bfm_dp #(
  parameter int unsigned PROG_DEPTH  = bfm_pkg::PROG_DEPTH_DEF,
  parameter int unsigned TAPE_CELLS  = bfm_pkg::TAPE_CELLS_DEF,
  parameter int unsigned STACK_DEPTH = bfm_pkg::STACK_DEPTH_DEF
) (
  input  wire               clk,
  input  wire               rst,
  input  bfm_pkg::cmd_t     cmd,
  input  wire  [7:0]        prog_char,
  input  wire               new_program,
  input  wire  [7:0]        in_byte,
  output bfm_pkg::sts_t     sts,
  output logic [2:0]        status,
  output logic              out_valid,
  output logic [7:0]        out_byte,
  output logic [12:0]       position,
  output logic [9:0]        head,
  output logic [7:0]        cell_value
);

  localparam int LW  = $clog2(PROG_DEPTH + 1);
  localparam int AW  = $clog2(PROG_DEPTH);
  localparam int TW  = $clog2(TAPE_CELLS);
  localparam int SCW = $clog2(STACK_DEPTH + 1);
  localparam int SW  = $clog2(STACK_DEPTH);

  logic [2:0]    prog_mem  [PROG_DEPTH];
  logic [AW-1:0] jump_mem  [PROG_DEPTH];
  logic [AW-1:0] stack_mem [STACK_DEPTH];
  logic [7:0]    tape_mem  [TAPE_CELLS];

  logic [LW-1:0]  prog_len, counter;
  logic [SCW-1:0] sc;
  logic [TW-1:0]  head_idx, clr;
  logic [2:0]     fault;
  logic [7:0]     cur_cell;
  logic [7:0]     ch_q, inb_q;
  logic           np_q;
  logic [2:0]     op_q;
  logic [AW-1:0]  jmp_q, stk_q, pos_q, partner_q;
  logic [2:0]     res_status;
  logic           res_ov;
  logic [7:0]     res_ob;

  // Load decisions; a fresh program sees its length, stack count and fault as cleared.
  bfm_pkg::dec_t  d;
  logic [LW-1:0]  len_eff;
  logic [SCW-1:0] sc_eff, sc_m1;
  logic [2:0]     fault_eff, fault_ld;
  logic           go, full_p, full_s, unm, store;

  always_comb begin
    d         = bfm_pkg::decode(ch_q);
    len_eff   = np_q ? '0 : prog_len;
    sc_eff    = np_q ? '0 : sc;
    fault_eff = np_q ? bfm_pkg::ST_OK : fault;
    go        = d.ok && (fault_eff != bfm_pkg::ST_BRACKET) && (fault_eff != bfm_pkg::ST_FULL);
    full_p    = (len_eff == LW'(PROG_DEPTH));
    full_s    = (d.op == bfm_pkg::OP_OPEN) && (sc_eff == SCW'(STACK_DEPTH));
    unm       = (d.op == bfm_pkg::OP_CLOSE) && (sc_eff == '0);
    store     = go && !full_p && !full_s && !unm;
    fault_ld  = fault_eff;
    if (go && (full_p || full_s)) begin
      fault_ld = bfm_pkg::ST_FULL;
    end else if (go && unm) begin
      fault_ld = bfm_pkg::ST_BRACKET;
    end
  end

  assign sc_m1 = sc - SCW'(1);

  // Step decisions.
  logic       blocked, at_end, edge_r, edge_l, jump_take;
  logic [2:0] st_early;

  always_comb begin
    at_end  = (counter >= prog_len);
    blocked = 1'b1;
    st_early = bfm_pkg::ST_OK;
    if (fault != bfm_pkg::ST_OK) begin
      st_early = fault;
    end else if (sc != '0) begin
      st_early = bfm_pkg::ST_BRACKET;
    end else if (at_end) begin
      st_early = bfm_pkg::ST_END;
    end else begin
      blocked = 1'b0;
    end
    edge_r    = (head_idx == TW'(TAPE_CELLS - 1));
    edge_l    = (head_idx == '0);
    jump_take = ((op_q == bfm_pkg::OP_OPEN) && (cur_cell == 8'd0)) ||
                ((op_q == bfm_pkg::OP_CLOSE) && (cur_cell != 8'd0));
  end

  assign sts.clr_last = (clr == TW'(TAPE_CELLS - 1));
  assign sts.close_ok = store && (d.op == bfm_pkg::OP_CLOSE);
  assign sts.moved    = !blocked && ((op_q == bfm_pkg::OP_RIGHT && !edge_r) ||
                                     (op_q == bfm_pkg::OP_LEFT && !edge_l));

  // Tape write port shared by the clearing pass and cell updates.
  logic       tw_en;
  logic [TW-1:0] tw_addr;
  logic [7:0] tw_data;

  always_comb begin
    tw_en   = 1'b0;
    tw_addr = head_idx;
    tw_data = 8'd0;
    if (cmd.clear) begin
      tw_en   = 1'b1;
      tw_addr = clr;
    end else if (cmd.exec && !blocked) begin
      case (op_q)
        bfm_pkg::OP_INC: begin tw_en = 1'b1; tw_data = cur_cell + 8'd1; end
        bfm_pkg::OP_DEC: begin tw_en = 1'b1; tw_data = cur_cell - 8'd1; end
        bfm_pkg::OP_IN:  begin tw_en = 1'b1; tw_data = inb_q; end
        default:         tw_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (tw_en) begin
      tape_mem[tw_addr] <= tw_data;
    end
    if (cmd.move) begin
      cur_cell <= tape_mem[head_idx];
    end else if (cmd.restart) begin
      cur_cell <= 8'd0;
    end else if (tw_en && !cmd.clear) begin
      cur_cell <= tw_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && store) begin
      prog_mem[len_eff[AW-1:0]] <= d.op;
    end
    op_q <= prog_mem[counter[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.close1) begin
      jump_mem[pos_q] <= stk_q;
    end else if (cmd.close2) begin
      jump_mem[partner_q] <= pos_q;
    end
    jmp_q <= jump_mem[counter[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load && store && (d.op == bfm_pkg::OP_OPEN)) begin
      stack_mem[sc_eff[SW-1:0]] <= len_eff[AW-1:0];
    end
    stk_q <= stack_mem[sc_m1[SW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ch_q  <= prog_char;
      np_q  <= new_program;
      inb_q <= in_byte;
    end
    if (cmd.load) begin
      pos_q <= len_eff[AW-1:0];
    end
    if (cmd.close1) begin
      partner_q <= stk_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prog_len <= '0;
      counter  <= '0;
      sc       <= '0;
      head_idx <= '0;
      fault    <= bfm_pkg::ST_OK;
      clr      <= '0;
    end else begin
      if (cmd.clr_init) begin
        clr <= '0;
      end else if (cmd.clear) begin
        clr <= clr + TW'(1);
      end
      if (cmd.restart) begin
        head_idx <= '0;
        counter  <= '0;
        if (fault == bfm_pkg::ST_TAPE) begin
          fault <= bfm_pkg::ST_OK;
        end
      end
      if (cmd.load) begin
        fault    <= fault_ld;
        prog_len <= store ? len_eff + LW'(1) : len_eff;
        if (store && (d.op == bfm_pkg::OP_OPEN)) begin
          sc <= sc_eff + SCW'(1);
        end else if (store && (d.op == bfm_pkg::OP_CLOSE)) begin
          sc <= sc_eff - SCW'(1);
        end else begin
          sc <= sc_eff;
        end
      end
      if (cmd.exec && !blocked) begin
        case (op_q)
          bfm_pkg::OP_RIGHT: begin
            if (edge_r) begin
              fault <= bfm_pkg::ST_TAPE;
            end else begin
              head_idx <= head_idx + TW'(1);
              counter  <= counter + LW'(1);
            end
          end
          bfm_pkg::OP_LEFT: begin
            if (edge_l) begin
              fault <= bfm_pkg::ST_TAPE;
            end else begin
              head_idx <= head_idx - TW'(1);
              counter  <= counter + LW'(1);
            end
          end
          bfm_pkg::OP_OPEN, bfm_pkg::OP_CLOSE: begin
            counter <= (jump_take ? LW'(jmp_q) : counter) + LW'(1);
          end
          default: counter <= counter + LW'(1);
        endcase
      end
    end
  end

  // Result registers, written no later than the controller raises done.
  always_ff @(posedge clk) begin
    if (cmd.load || cmd.restart || cmd.nop || cmd.exec) begin
      res_ov <= 1'b0;
      res_ob <= 8'd0;
    end
    if (cmd.load) begin
      res_status <= fault_ld;
    end else if (cmd.restart) begin
      res_status <= (fault == bfm_pkg::ST_TAPE) ? bfm_pkg::ST_OK : fault;
    end else if (cmd.nop) begin
      res_status <= fault;
    end else if (cmd.exec) begin
      if (blocked) begin
        res_status <= st_early;
      end else if ((op_q == bfm_pkg::OP_RIGHT && edge_r) ||
                   (op_q == bfm_pkg::OP_LEFT && edge_l)) begin
        res_status <= bfm_pkg::ST_TAPE;
      end else begin
        res_status <= bfm_pkg::ST_OK;
        if (op_q == bfm_pkg::OP_OUT) begin
          res_ov <= 1'b1;
          res_ob <= cur_cell;
        end
      end
    end
  end

  assign status     = res_status;
  assign out_valid  = res_ov;
  assign out_byte   = res_ob;
  assign position   = 13'(counter);
  assign head       = 10'(head_idx);
  assign cell_value = cur_cell;

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    prog_len <= LW'(PROG_DEPTH)) else $error("program length past store depth");
  a_sc_bound: assert property (@(posedge clk) disable iff (rst)
    sc <= SCW'(STACK_DEPTH)) else $error("bracket stack overflow");
  a_move_fault: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && !blocked && op_q == bfm_pkg::OP_RIGHT && edge_r) |=>
      (fault == bfm_pkg::ST_TAPE && $stable(head_idx)))
    else $error("head left the tape");
  a_restart: assert property (@(posedge clk) disable iff (rst)
    cmd.restart |=> (head_idx == '0 && counter == '0 && cur_cell == 8'd0))
    else $error("restart left machine state behind");

endmodule
`default_nettype wire

>>> hdl/brainfuck_machine_step.sv
// Top level of the Brainfuck machine: controller plus datapath.
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------
//  item in  | start & !busy        | action, prog_char, new_program, in_byte
//  result   | done (one cycle)     | status, out_valid, out_byte, position,
//           |                      | head, cell_value
//
// A step passes through the step state, and also the move state when the head
// moves (the tape read of the new cell). A load passes through the load state,
// and for a matched ']' also CLOSE1 and CLOSE2 (two jump store writes). A restart
// runs a clearing pass over the tape; after reset the same pass runs with busy high.
// Results cannot be stalled; done marks the single cycle they are valid.
`timescale 1ns / 1ps
`default_nettype none
module brainfuck_machine_step #(
  parameter int unsigned PROG_DEPTH  = bfm_pkg::PROG_DEPTH_DEF,
  parameter int unsigned TAPE_CELLS  = bfm_pkg::TAPE_CELLS_DEF,
  parameter int unsigned STACK_DEPTH = bfm_pkg::STACK_DEPTH_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  output logic        busy,
  input  wire  [1:0]  action,
  input  wire  [7:0]  prog_char,
  input  wire         new_program,
  input  wire  [7:0]  in_byte,
  output logic        done,
  output logic [2:0]  status,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic [12:0] position,
  output logic [9:0]  head,
  output logic [7:0]  cell_value
);

  bfm_pkg::cmd_t cmd;
  bfm_pkg::sts_t sts;

  bfm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .sts    (sts),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd)
  );

  bfm_dp #(
    .PROG_DEPTH  (PROG_DEPTH),
    .TAPE_CELLS  (TAPE_CELLS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .prog_char   (prog_char),
    .new_program (new_program),
    .in_byte     (in_byte),
    .sts         (sts),
    .status      (status),
    .out_valid   (out_valid),
    .out_byte    (out_byte),
    .position    (position),
    .head        (head),
    .cell_value  (cell_value)
  );

endmodule
`default_nettype wire
